FILE: sv/crp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crp_pkg;

  localparam int unsigned CHANNELS_DEFAULT = 32;
  localparam int unsigned BINS_DEFAULT     = 10;
  localparam logic [31:0] WIDTH_RESET      = 32'd60000;
  localparam logic [31:0] NONE_YET         = 32'hFFFF_FFFF;
  localparam logic [31:0] SUM_LIMIT        = 32'd1000000000;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_EVENT = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_HREAD,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  channel;
    logic [31:0] raw_count;
    logic [3:0]  bin_select;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] runtime;
    logic [31:0] event_count;
    logic [31:0] run_min;
    logic [31:0] run_max;
    logic [31:0] idle_min;
    logic [31:0] idle_max;
    logic [63:0] runtime_sum;
    logic [3:0]  bin_index;
    logic [31:0] bin_count;
  } out_item_t;

  // per-channel record held in the statistics memory
  typedef struct packed {
    logic [63:0] start_time;
    logic [63:0] stop_time;
    logic [63:0] last_runtime;
    logic [31:0] events;
    logic [31:0] run_min;
    logic [31:0] run_max;
    logic [31:0] gap_min;
    logic [31:0] gap_max;
    logic [63:0] total;
  } chan_rec_t;

endpackage
`default_nettype wire

FILE: sv/channel_runtime_profiler.sv
// start, plain event and read pass through the read, calc, hread and write states to the result;
// a stop also passes through the div state, where the 4-bit bin quotient is searched;
// an out-of-range channel goes from the read state straight to the result
// one transaction at a time: the next is accepted only after the result is taken
// reset: a clearing pass walks both memories (channel records and histogram) before the
// first transaction; a histogram clear pass follows each width write
`timescale 1ns / 1ps
`default_nettype none
module channel_runtime_profiler #(
  parameter int unsigned CHANNELS = crp_pkg::CHANNELS_DEFAULT,
  parameter int unsigned BINS     = crp_pkg::BINS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire crp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output crp_pkg::out_item_t      out_data
);
  import crp_pkg::*;

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned HW    = CW + 4;
  localparam int unsigned HD    = CHANNELS * 16;
  localparam logic [HW-1:0] HLAST = HW'(HD - 1);

  // memories
  chan_rec_t   rec_mem [CHANNELS];
  logic [31:0] hist_mem [HD];
  chan_rec_t   rec_q;
  logic [31:0] hist_q;

  state_t      state, state_next;
  in_item_t    item;
  chan_rec_t   rec;
  logic [31:0] bin_width;
  logic [31:0] wrap_count;
  logic [31:0] previous_raw;
  logic [HW-1:0] clr_addr;
  logic        clr_rec;
  logic [31:0] rt;
  logic [31:0] rem;
  logic [3:0]  quo;
  logic [4:0]  step;
  logic [3:0]  bidx;
  logic [31:0] bcnt;
  logic        bad;

  logic [CW-1:0]   ch;
  logic [CW-1:0]   rec_raddr;
  logic [HW-1:0]   haddr;
  logic            rec_we, hist_we;
  logic [HW-1:0]   hist_waddr;
  logic [CW-1:0]   rec_waddr;
  logic [31:0]     hist_wdata;
  chan_rec_t       rec_wdata;
  chan_rec_t       rec_reset;
  logic [63:0]     t_ext;
  logic [31:0]     wrap_ext;
  logic [32:0]     sub;
  logic [3:0]      qlast;

  assign ch    = item.channel[CW-1:0];
  assign haddr = {ch, bidx};
  assign qlast = 4'(BINS - 1);

  // record read address follows the incoming transaction while idle
  assign rec_raddr = (state == ST_IDLE) ? in_data.channel[CW-1:0] : ch;

  always_comb begin
    rec_reset              = '0;
    rec_reset.run_min      = NONE_YET;
    rec_reset.gap_min      = NONE_YET;
  end

  // time base extension from the sampled count
  assign wrap_ext = (item.raw_count < previous_raw) ? wrap_count + 32'd1 : wrap_count;
  assign t_ext    = {wrap_ext, item.raw_count};

  // restoring divider step: one quotient bit per cycle (4 bits)
  assign sub = {1'b0, rem} - ({1'b0, bin_width} << step[1:0]);

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == HLAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cfg_valid) state_next = ST_CLEAR;
        else if (in_valid) state_next = ST_READ;
      end
      ST_READ:  state_next = bad ? ST_OUT : ST_CALC;
      ST_CALC:  state_next = (item.kind == KIND_STOP) ? ST_DIV : ST_HREAD;
      ST_DIV:   if (step == 5'd4) state_next = ST_HREAD;
      ST_HREAD: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory write controls
  always_comb begin
    rec_we     = 1'b0;
    hist_we    = 1'b0;
    rec_waddr  = ch;
    hist_waddr = haddr;
    rec_wdata  = rec;
    hist_wdata = bcnt;
    unique case (state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_addr;
        hist_wdata = '0;
        rec_we     = clr_rec && (clr_addr[3:0] == 4'd0);
        rec_waddr  = clr_addr[HW-1:4];
        rec_wdata  = rec_reset;
      end
      ST_WRITE: begin
        rec_we     = 1'b1;
        hist_we    = (item.kind == KIND_STOP);
        hist_wdata = hist_q + 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    rec_q  <= rec_mem[rec_raddr];
    hist_q <= hist_mem[haddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      clr_rec      <= 1'b1;
      bin_width    <= WIDTH_RESET;
      wrap_count   <= '0;
      previous_raw <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == HLAST) clr_rec <= 1'b0;
      end
      if (state == ST_IDLE && cfg_valid) begin
        bin_width <= cfg_data;
        clr_addr  <= '0;
      end
      if (state == ST_CALC && (item.kind == KIND_START || item.kind == KIND_STOP)) begin
        wrap_count   <= wrap_ext;
        previous_raw <= item.raw_count;
      end
      out_valid <= (state_next == ST_OUT);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item <= in_data;
        bad  <= (32'(in_data.channel) >= CHANNELS);
        bidx <= in_data.bin_select;
      end
      ST_READ: rec <= rec_q;
      ST_CALC: begin
        unique case (kind_t'(item.kind))
          KIND_START: begin
            rec.events     <= rec.events + 32'd1;
            rec.start_time <= t_ext;
            if (rec.stop_time != 64'd0) begin
              if (32'(t_ext - rec.stop_time) < rec.gap_min)
                rec.gap_min <= 32'(t_ext - rec.stop_time);
              if (32'(t_ext - rec.stop_time) > rec.gap_max)
                rec.gap_max <= 32'(t_ext - rec.stop_time);
            end
          end
          KIND_STOP: begin
            rec.stop_time    <= t_ext;
            rec.last_runtime <= t_ext - rec.start_time;
            rt   <= 32'(t_ext - rec.start_time);
            rem  <= 32'(t_ext - rec.start_time);
            quo  <= '0;
            step <= 5'd3;
          end
          KIND_EVENT: rec.events <= rec.events + 32'd1;
          KIND_READ: ;
          default: ;
        endcase
      end
      ST_DIV: begin
        if (step == 5'd4) begin
          // finalize bin: saturate
          if (bin_width == 32'd0 || rem >= bin_width || quo > qlast) bidx <= qlast;
          else bidx <= quo;
          step <= 5'd0;
        end else begin
          if (!sub[32] && (bin_width << step[1:0]) >> step[1:0] == bin_width) begin
            rem <= sub[31:0];
            quo[step[1:0]] <= 1'b1;
          end
          step <= (step[1:0] == 2'd0) ? 5'd4 : step - 5'd1;
        end
        if (rt < SUM_LIMIT && step == 5'd3) rec.total <= rec.total + {32'd0, rt};
        if (step == 5'd3) begin
          if (rt < rec.run_min) rec.run_min <= rt;
          if (rt > rec.run_max) rec.run_max <= rt;
        end
      end
      ST_HREAD: ;
      ST_WRITE: begin
        if (item.kind == KIND_STOP) bcnt <= hist_q + 32'd1;
        else if (item.kind == KIND_READ && {1'b0, item.bin_select} < 5'(BINS))
          bcnt <= hist_q;
        else bcnt <= '0;
      end
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    out_data = '0;
    if (bad) begin
      out_data.status = 1'b1;
    end else begin
      out_data.runtime     = rec.last_runtime;
      out_data.event_count = rec.events;
      out_data.run_min     = rec.run_min;
      out_data.run_max     = rec.run_max;
      out_data.idle_min    = rec.gap_min;
      out_data.idle_max    = rec.gap_max;
      out_data.runtime_sum = rec.total;
      if (item.kind == KIND_STOP || item.kind == KIND_READ) begin
        out_data.bin_index = bidx;
        out_data.bin_count = bcnt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/channel_runtime_profiler_test.sv
`timescale 1ns / 1ps
module channel_runtime_profiler_test;
  import crp_pkg::*;

  localparam int NCH = 32;
  localparam int NBIN = 10;
  localparam int STALL_LIMIT = 20000;

  // expected-statistics tracker for the profiler
  class profile_board;
    logic [31:0] width;
    logic [31:0] wraps;
    logic [31:0] prev_raw;
    logic [63:0] t_start [NCH];
    logic [63:0] t_stop [NCH];
    logic [63:0] last_rt [NCH];
    logic [31:0] evts [NCH];
    logic [31:0] rmin [NCH];
    logic [31:0] rmax [NCH];
    logic [31:0] gmin [NCH];
    logic [31:0] gmax [NCH];
    logic [63:0] rsum [NCH];
    logic [31:0] hist [NCH][NBIN];
    out_item_t pending [$];
    int errors;

    function new();
      width = WIDTH_RESET;
      wraps = 0;
      prev_raw = 0;
      errors = 0;
      for (int c = 0; c < NCH; c++) begin
        t_start[c] = 0; t_stop[c] = 0; last_rt[c] = 0; evts[c] = 0;
        rmin[c] = NONE_YET; rmax[c] = 0; gmin[c] = NONE_YET; gmax[c] = 0;
        rsum[c] = 0;
        for (int b = 0; b < NBIN; b++) hist[c][b] = 0;
      end
    endfunction

    function void set_width(logic [31:0] w);
      width = w;
      for (int c = 0; c < NCH; c++)
        for (int b = 0; b < NBIN; b++) hist[c][b] = 0;
    endfunction

    function logic [63:0] extend(logic [31:0] raw);
      if (raw < prev_raw) wraps = wraps + 1;
      prev_raw = raw;
      return {wraps, raw};
    endfunction

    // note an accepted input transaction and queue its expected result
    function void note_input(in_item_t it);
      out_item_t r;
      int ch;
      logic [63:0] t;
      logic [31:0] rt, q, gap;
      r = '0;
      ch = it.channel;
      if (it.channel >= NCH) begin
        r.status = 1'b1;
        pending.push_back(r);
        return;
      end
      case (kind_t'(it.kind))
        KIND_START: begin
          t = extend(it.raw_count);
          evts[ch] = evts[ch] + 1;
          t_start[ch] = t;
          if (t_stop[ch] != 0) begin
            gap = 32'(t - t_stop[ch]);
            if (gap < gmin[ch]) gmin[ch] = gap;
            if (gap > gmax[ch]) gmax[ch] = gap;
          end
        end
        KIND_STOP: begin
          t = extend(it.raw_count);
          t_stop[ch] = t;
          last_rt[ch] = t - t_start[ch];
          rt = last_rt[ch][31:0];
          if (rt < rmin[ch]) rmin[ch] = rt;
          if (rt > rmax[ch]) rmax[ch] = rt;
          q = (width != 0) ? rt / width : 32'hFFFF_FFFF;
          if (q > NBIN - 1) q = NBIN - 1;
          hist[ch][q] = hist[ch][q] + 1;
          r.bin_index = q[3:0];
          r.bin_count = hist[ch][q];
          if (rt < SUM_LIMIT) rsum[ch] = rsum[ch] + {32'd0, rt};
        end
        KIND_EVENT: evts[ch] = evts[ch] + 1;
        default: begin
          r.bin_index = it.bin_select;
          r.bin_count = (it.bin_select < NBIN) ? hist[ch][it.bin_select] : 32'd0;
        end
      endcase
      r.runtime = last_rt[ch];
      r.event_count = evts[ch];
      r.run_min = rmin[ch];
      r.run_max = rmax[ch];
      r.idle_min = gmin[ch];
      r.idle_max = gmax[ch];
      r.runtime_sum = rsum[ch];
      pending.push_back(r);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        $display("%0t: status exp %h got %h", $realtime, e.status, got.status);
      if (got.runtime !== e.runtime)
        $display("%0t: runtime exp %h got %h", $realtime, e.runtime, got.runtime);
      if (got.event_count !== e.event_count)
        $display("%0t: event_count exp %h got %h", $realtime, e.event_count,
                 got.event_count);
      if (got.run_min !== e.run_min)
        $display("%0t: run_min exp %h got %h", $realtime, e.run_min, got.run_min);
      if (got.run_max !== e.run_max)
        $display("%0t: run_max exp %h got %h", $realtime, e.run_max, got.run_max);
      if (got.idle_min !== e.idle_min)
        $display("%0t: idle_min exp %h got %h", $realtime, e.idle_min, got.idle_min);
      if (got.idle_max !== e.idle_max)
        $display("%0t: idle_max exp %h got %h", $realtime, e.idle_max, got.idle_max);
      if (got.runtime_sum !== e.runtime_sum)
        $display("%0t: runtime_sum exp %h got %h", $realtime, e.runtime_sum,
                 got.runtime_sum);
      if (got.bin_index !== e.bin_index)
        $display("%0t: bin_index exp %h got %h", $realtime, e.bin_index, got.bin_index);
      if (got.bin_count !== e.bin_count)
        $display("%0t: bin_count exp %h got %h", $realtime, e.bin_count, got.bin_count);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  in_item_t in_data;
  logic out_valid, out_ready;
  out_item_t out_data;

  profile_board board;
  int stalls;
  logic [31:0] clock_now;
  bit sink_on;

  channel_runtime_profiler DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog over cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || rst)
      stalls <= 0;
    else
      stalls <= stalls + 1;
    if (stalls >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // result side ready with random stalls
  initial begin
    int wait_n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      wait_n = sink_on ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      repeat (wait_n) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_width(logic [31:0] w);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_width(w);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(in_item_t it, int gap_n);
    if (gap_n > 0) begin
      in_valid <= 1'b0;
      repeat (gap_n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic in_item_t make(kind_t k, int ch, logic [31:0] raw, logic [3:0] sel);
    in_item_t it;
    it.kind = k;
    it.channel = ch[7:0];
    it.raw_count = raw;
    it.bin_select = sel;
    return it;
  endfunction

  // random item: mostly start/stop on valid channels with advancing time, with occasional jumps
  function automatic in_item_t rand_item();
    int r;
    int ch;
    r = $urandom_range(0, 99);
    ch = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NCH - 1);
    if ($urandom_range(0, 9) == 0)
      clock_now = $urandom;
    else
      clock_now = clock_now + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000000)
                                                          : $urandom_range(0, 400000));
    if (r < 38) return make(KIND_START, ch, clock_now, 4'($urandom));
    if (r < 76) return make(KIND_STOP, ch, clock_now, 4'($urandom));
    if (r < 86) return make(KIND_EVENT, ch, $urandom, 4'($urandom));
    return make(KIND_READ, ch, $urandom, 4'($urandom));
  endfunction

  initial begin
    logic [31:0] widths [5];
    int gap_n;
    board = new();
    stalls = 0;
    sink_on = 1'b0;
    clock_now = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, wraps, out of range, every kind
    send_item(make(KIND_READ, 0, 0, 4'd0), 0);
    send_item(make(KIND_START, 0, 32'd100, 4'd0), 0);
    send_item(make(KIND_STOP, 0, 32'd200, 4'd0), 0);
    send_item(make(KIND_START, 0, 32'd5000, 4'd0), 0);
    send_item(make(KIND_STOP, 0, 32'd700000, 4'd0), 0);
    send_item(make(KIND_READ, 0, 0, 4'd9), 0);
    send_item(make(KIND_READ, 0, 0, 4'd15), 0);
    send_item(make(KIND_START, NCH - 1, 32'hFFFF_FFF0, 4'hF), 0);
    send_item(make(KIND_STOP, NCH - 1, 32'h0000_0010, 4'hF), 0);
    send_item(make(KIND_START, NCH - 1, 32'hFFFF_FFFF, 4'hF), 0);
    send_item(make(KIND_STOP, NCH - 1, 32'hFFFF_FFFF, 4'hF), 0);
    send_item(make(KIND_EVENT, 5, 32'hFFFF_FFFF, 4'h0), 0);
    send_item(make(KIND_START, NCH, 32'h0, 4'h0), 0);
    send_item(make(KIND_STOP, 255, 32'hFFFF_FFFF, 4'hF), 0);
    send_item(make(KIND_READ, 128, 32'h0, 4'h3), 0);
    send_item(make(KIND_READ, NCH - 1, 32'h0, 4'd10), 0);
    drain();
    write_width(32'd0);
    send_item(make(KIND_START, 3, 32'd10, 4'd0), 0);
    send_item(make(KIND_STOP, 3, 32'd11, 4'd0), 0);
    send_item(make(KIND_READ, 0, 0, 4'd9), 0);
    drain();
    write_width(32'hFFFF_FFFF);
    send_item(make(KIND_START, 4, 32'd0, 4'd0), 0);
    send_item(make(KIND_STOP, 4, 32'hFFFF_FFFE, 4'd0), 0);
    send_item(make(KIND_READ, 4, 0, 4'd0), 0);
    drain();

    // random phases across bin width settings
    sink_on = 1'b1;
    widths[0] = 32'd1;
    widths[1] = 32'd60000;
    widths[2] = 32'd0;
    widths[3] = 32'd50000;
    widths[4] = 32'hFFFF_FFFF;
    for (int p = 0; p < 5; p++) begin
      write_width(p == 3 ? 32'($urandom_range(1000, 200000)) : widths[p]);
      for (int i = 0; i < 108; i++) begin
        gap_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        send_item(rand_item(), gap_n);
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
